@@ hdl/ibe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibe_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package ibe_pkg;

  localparam int DIVIDER_BITS_DEF = 8;
  localparam int SCAN_END_DEF     = 127;
  localparam int QDEPTH           = 2;
  localparam logic [7:0] HALF_PERIOD_RST = 8'd4;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_SCAN  = 3'd4;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] op;
    logic [6:0] target_address;
    logic       read_flag;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] read_byte;
    logic [6:0] scan_total;
  } out_item_t;

  typedef struct packed {
    logic       cmd_ok;
    logic [2:0] op;
    logic [6:0] target_address;
    logic       read_flag;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;
  } tick_t;

endpackage
`default_nettype wire

@@ hdl/ibe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibe_front
// Accepts ticks and classifies the offered command as runnable or not.
// ----------------------------------------------------------------------------
module ibe_front (
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  ibe_pkg::in_item_t in_data_i,
  input  wire              q_full_i,
  output logic             q_push_o,
  output ibe_pkg::tick_t   q_data_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o.cmd_ok         = in_data_i.cmd_valid && (in_data_i.op <= ibe_pkg::OP_SCAN);
    q_data_o.op             = in_data_i.op;
    q_data_o.target_address = in_data_i.target_address;
    q_data_o.read_flag      = in_data_i.read_flag;
    q_data_o.write_data     = in_data_i.write_data;
    q_data_o.send_ack       = in_data_i.send_ack;
    q_data_o.sda_sample     = in_data_i.sda_sample;
  end

endmodule
`default_nettype wire

@@ hdl/ibe_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibe_queue
// Short register queue between the front and the bus sequencer.
// ----------------------------------------------------------------------------
module ibe_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  ibe_pkg::tick_t  push_data_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            empty_o,
  output ibe_pkg::tick_t  pop_data_o
);

  localparam int PTR_W = (ibe_pkg::QDEPTH > 1) ? $clog2(ibe_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(ibe_pkg::QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ibe_pkg::QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ibe_pkg::QDEPTH);

  ibe_pkg::tick_t   mem_q [ibe_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_FULL);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

@@ hdl/ibe_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibe_back
// Bus sequencer: runs one tick per queued transaction and registers the
// resulting line levels and status.
// ----------------------------------------------------------------------------
module ibe_back #(
  parameter int DIVIDER_BITS = ibe_pkg::DIVIDER_BITS_DEF,
  parameter int SCAN_END     = ibe_pkg::SCAN_END_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [7:0]        cfg_wdata_i,
  input  wire               q_empty_i,
  input  ibe_pkg::tick_t    q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output ibe_pkg::out_item_t out_data_o
);

  localparam int DW = DIVIDER_BITS;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_START_HI  = 4'd1;
  localparam logic [3:0] PH_START_SDA = 4'd2;
  localparam logic [3:0] PH_TX_LOW    = 4'd3;
  localparam logic [3:0] PH_TX_HIGH   = 4'd4;
  localparam logic [3:0] PH_RX_LOW    = 4'd5;
  localparam logic [3:0] PH_RX_HIGH   = 4'd6;
  localparam logic [3:0] PH_STOP_LOW  = 4'd7;
  localparam logic [3:0] PH_STOP_HIGH = 4'd8;

  localparam logic [6:0] SCAN_LAST = 7'(SCAN_END);

  logic [7:0]    hp_q;
  logic [3:0]    ph_q, ph_d;
  logic [3:0]    bi_q, bi_d;
  logic [7:0]    sb_q, sb_d;
  logic [DW-1:0] tc_q, tc_d;
  logic [2:0]    aop_q, aop_d;
  logic [6:0]    pa_q, pa_d;
  logic [6:0]    hits_q, hits_d;
  logic          ack_q, ack_d;
  logic          scl_q, scl_d;
  logic          sda_q, sda_d;
  logic          ackc_q, ackc_d;
  logic [7:0]    lastr_q, lastr_d;

  logic               out_valid_q;
  ibe_pkg::out_item_t out_q, res;

  logic          fire;
  logic [DW-1:0] lim;
  logic [DW-1:0] tc_inc;
  logic          tx_bit;
  logic          busy, done;
  logic          o_scl, o_sda;

  assign fire        = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o     = fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    ph_d    = ph_q;
    bi_d    = bi_q;
    sb_d    = sb_q;
    tc_d    = tc_q;
    aop_d   = aop_q;
    pa_d    = pa_q;
    hits_d  = hits_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ackc_d  = ackc_q;
    lastr_d = lastr_q;
    busy    = 1'b0;
    done    = 1'b0;
    tx_bit  = 1'b1;
    lim     = DW'(hp_q);
    if (lim == '0) begin
      lim = DW'(1);
    end
    tc_inc  = '0;

    if (ph_q == PH_IDLE && q_data_i.cmd_ok) begin
      aop_d = q_data_i.op;
      tc_d  = '0;
      bi_d  = '0;
      case (q_data_i.op)
        ibe_pkg::OP_START: begin
          sb_d = {q_data_i.target_address, q_data_i.read_flag};
          ph_d = PH_START_HI;
        end
        ibe_pkg::OP_WRITE: begin
          sb_d = q_data_i.write_data;
          ph_d = PH_TX_LOW;
        end
        ibe_pkg::OP_READ: begin
          sb_d   = '0;
          ackc_d = q_data_i.send_ack;
          ph_d   = PH_RX_LOW;
        end
        ibe_pkg::OP_STOP: begin
          ph_d = PH_STOP_LOW;
        end
        default: begin
          pa_d   = 7'd1;
          hits_d = '0;
          sb_d   = 8'd2;
          ph_d   = PH_START_HI;
        end
      endcase
    end

    if (!bi_d[3]) begin
      tx_bit = sb_d[~bi_d[2:0]];
    end

    if (ph_d != PH_IDLE) begin
      busy = 1'b1;
      if (tc_d == '0) begin
        case (ph_d)
          PH_START_HI:  begin scl_d = 1'b1; sda_d = 1'b1;   end
          PH_START_SDA: begin scl_d = 1'b1; sda_d = 1'b0;   end
          PH_TX_LOW:    begin scl_d = 1'b0; sda_d = tx_bit; end
          PH_TX_HIGH:   begin scl_d = 1'b1; sda_d = tx_bit; end
          PH_RX_LOW, PH_RX_HIGH: begin
            scl_d = (ph_d == PH_RX_HIGH);
            sda_d = bi_d[3] ? !ackc_d : 1'b1;
          end
          PH_STOP_LOW:  begin scl_d = 1'b0; sda_d = 1'b0;   end
          PH_STOP_HIGH: begin scl_d = 1'b1; sda_d = 1'b0;   end
          default: ;
        endcase
      end
      o_scl  = scl_d;
      o_sda  = sda_d;
      tc_inc = DW'(tc_d + 1'b1);
      tc_d   = tc_inc;
      if (tc_inc >= lim || tc_inc == '0) begin
        tc_d = '0;
        case (ph_d)
          PH_START_HI: begin
            ph_d = PH_START_SDA;
          end
          PH_START_SDA: begin
            ph_d = PH_TX_LOW;
            bi_d = '0;
          end
          PH_TX_LOW: begin
            ph_d = PH_TX_HIGH;
          end
          PH_TX_HIGH: begin
            if (!bi_d[3]) begin
              bi_d = 4'(bi_d + 1'b1);
              ph_d = PH_TX_LOW;
            end else begin
              ack_d = !q_data_i.sda_sample;
              if (aop_d == ibe_pkg::OP_SCAN) begin
                if (ack_d) begin
                  hits_d = 7'(hits_d + 1'b1);
                end
                ph_d = PH_STOP_LOW;
              end else begin
                sda_d = 1'b1;
                done  = 1'b1;
              end
            end
          end
          PH_RX_LOW: begin
            ph_d = PH_RX_HIGH;
          end
          PH_RX_HIGH: begin
            if (!bi_d[3]) begin
              sb_d = {sb_d[6:0], q_data_i.sda_sample};
              bi_d = 4'(bi_d + 1'b1);
              ph_d = PH_RX_LOW;
            end else begin
              lastr_d = sb_d;
              scl_d   = 1'b0;
              sda_d   = 1'b1;
              done    = 1'b1;
            end
          end
          PH_STOP_LOW: begin
            ph_d = PH_STOP_HIGH;
          end
          PH_STOP_HIGH: begin
            sda_d = 1'b1;
            if (aop_d == ibe_pkg::OP_SCAN && pa_d < SCAN_LAST) begin
              pa_d = 7'(pa_d + 1'b1);
              sb_d = {pa_d, 1'b0};
              ph_d = PH_START_HI;
            end else begin
              done = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          ph_d = PH_IDLE;
        end
      end
    end else begin
      o_scl = scl_d;
      o_sda = sda_d;
    end

    res.scl_drive  = o_scl;
    res.sda_drive  = o_sda;
    res.busy_res   = busy;
    res.done_res   = done;
    res.ack_seen   = ack_d;
    res.read_byte  = lastr_d;
    res.scan_total = hits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q        <= ibe_pkg::HALF_PERIOD_RST;
      ph_q        <= PH_IDLE;
      bi_q        <= '0;
      sb_q        <= '0;
      tc_q        <= '0;
      aop_q       <= '0;
      pa_q        <= '0;
      hits_q      <= '0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ackc_q      <= 1'b0;
      lastr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hp_q <= cfg_wdata_i;
      end
      if (fire) begin
        ph_q    <= ph_d;
        bi_q    <= bi_d;
        sb_q    <= sb_d;
        tc_q    <= tc_d;
        aop_q   <= aop_d;
        pa_q    <= pa_d;
        hits_q  <= hits_d;
        ack_q   <= ack_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        ackc_q  <= ackc_d;
        lastr_q <= lastr_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

endmodule
`default_nettype wire

@@ hdl/i2c_master_bit_engine_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// Open-drain I2C master bit engine: one transaction per timing tick in, one
// transaction of line levels and status out.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  ibe_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i ibe_pkg::out_item_t
//   cfg      input      cfg_we_i                cfg_wdata_i (half period)
//
// One tick per clock cycle sustained while the output is not stalled. The
// sequencer update of one tick is combinational; a two-entry queue
// decouples the front from the sequencer and the output register.
// Reset clears the queue, the sequencer to idle with both lines released
// and the half period to 4. A stalled output holds its transaction; the
// input stalls only when the queue fills.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit #(
  parameter int DIVIDER_BITS = ibe_pkg::DIVIDER_BITS_DEF,
  parameter int SCAN_END     = ibe_pkg::SCAN_END_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  ibe_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output ibe_pkg::out_item_t out_data_o,
  input  wire                cfg_we_i,
  input  wire  [7:0]         cfg_wdata_i
);

  logic           q_full, q_empty, q_push, q_pop;
  ibe_pkg::tick_t q_wdata, q_rdata;

  ibe_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  ibe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  ibe_back #(
    .DIVIDER_BITS (DIVIDER_BITS),
    .SCAN_END     (SCAN_END)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ hdl/ibe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibe_checker
// Port-level checks of the I2C master bit engine.
// ----------------------------------------------------------------------------
module ibe_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input ibe_pkg::out_item_t out_data_o,
  input wire                out_valid_o,
  input wire                out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.done_res || out_data_o.busy_res))
    else $error("done without busy");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_stall_o && !out_valid_o)
    else $error("queue or output not empty after reset");

  a_stall_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(in_valid_i) || $past(in_stall_o))
    else $error("input stalled with no transaction taken");

endmodule

bind i2c_master_bit_engine_unit ibe_checker u_ibe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
`default_nettype wire
